[hw/rtl/lbr_pkg.sv]
// Shared constants, payload types and controller/datapath interface types.
package lbr_pkg;

    localparam int MAX_BLOCK_DEGREE = 3;
    localparam int MAX_CHANNELS     = 4;
    localparam int MAX_BLOCK_COLS   = 64;
    localparam int MAX_BLOCK_ROWS   = 64;

    localparam int EDGE_MAX    = 1 << MAX_BLOCK_DEGREE;
    localparam int AREA_MAX    = EDGE_MAX * EDGE_MAX;
    localparam int SAMPLES_MAX = AREA_MAX * MAX_CHANNELS;
    localparam int STRIDE_MAX  = EDGE_MAX * MAX_CHANNELS;
    localparam int UP_DEPTH    = MAX_BLOCK_COLS * STRIDE_MAX;
    localparam int LEFT_DEPTH  = MAX_BLOCK_ROWS * STRIDE_MAX;
    localparam int CLR_DEPTH   = (UP_DEPTH > LEFT_DEPTH) ? UP_DEPTH : LEFT_DEPTH;

    localparam int SAW  = $clog2(SAMPLES_MAX);
    localparam int CAW  = $clog2(CLR_DEPTH);
    localparam int CNTW = $clog2(SAMPLES_MAX + 1);
    localparam int POSW = $clog2(AREA_MAX);
    localparam int OW   = $clog2(STRIDE_MAX);
    localparam int INW  = $clog2(EDGE_MAX);
    localparam int CW   = $clog2(MAX_CHANNELS);
    localparam int DEGW = 2;
    localparam int CHW  = 3;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd_code;

    localparam logic [1:0] CFG_DEGREE   = 2'd0;
    localparam logic [1:0] CFG_CHANNELS = 2'd1;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] sample;
        logic [7:0] code;
        logic [5:0] block_col;
        logic [5:0] block_row;
    } t_in_item;

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
        logic       not_ready;
    } t_out_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RO_RD,
        ST_RO_WR,
        ST_CA_RS,
        ST_CA_R0,
        ST_CA_W0,
        ST_CA_R1,
        ST_CA_W1,
        ST_H_CTX,
        ST_H_RD,
        ST_H_WR,
        ST_H_CWR,
        ST_V_CTX,
        ST_V_RD,
        ST_V_WR,
        ST_V_CWR
    } t_state;

    typedef struct packed {
        t_state          op;
        logic [CAW-1:0]  idx;
        logic [CW-1:0]   chan;
        logic [POSW-1:0] pos;
        logic [OW-1:0]   outer;
        logic [INW-1:0]  inner;
    } t_dp_cmd;

    typedef struct packed {
        logic [DEGW-1:0] deg;
        logic [CHW-1:0]  chans;
        logic [7:0]      code;
        logic [SAW-1:0]  total_m1;
        logic [POSW-1:0] area_m1;
        logic [OW-1:0]   stride_m1;
        logic            load_last;
    } t_dp_stat;

endpackage

[hw/rtl/lbr_ctrl.sv]
// Sequencer for clear pass and block rebuild: state machine and loop counters.
module lbr_ctrl import lbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_cmd,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output t_dp_cmd    o_dp
);

    t_state          r_state, n_state;
    logic [CAW-1:0]  r_idx, n_idx;
    logic [CW-1:0]   r_chan, n_chan;
    logic [POSW-1:0] r_pos, n_pos;
    logic [OW-1:0]   r_outer, n_outer;
    logic [INW-1:0]  r_inner, n_inner;

    logic [INW-1:0]  edge_m1;
    logic [CW-1:0]   chan_m1;
    logic            colour_on;

    assign edge_m1   = INW'((5'd1 << i_stat.deg) - 5'd1);
    assign chan_m1   = CW'(i_stat.chans - 3'd1);
    assign colour_on = (i_stat.chans >= 3'd3) && (i_stat.code[3:2] != 2'd0)
                       && (i_stat.code[1:0] != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_chan  <= '0;
            r_pos   <= '0;
            r_outer <= '0;
            r_inner <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_chan  <= n_chan;
            r_pos   <= n_pos;
            r_outer <= n_outer;
            r_inner <= n_inner;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_chan  = r_chan;
        n_pos   = r_pos;
        n_outer = r_outer;
        n_inner = r_inner;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    if (i_cmd == CMD_CLEAR) begin
                        n_state = ST_CLEAR;
                        n_idx   = '0;
                    end else if (i_cmd == CMD_LOAD && i_stat.load_last) begin
                        n_state = ST_RO_RD;
                        n_idx   = '0;
                        n_chan  = '0;
                        n_pos   = '0;
                    end
                end
            end
            ST_CLEAR: begin
                if (r_idx == CAW'(CLR_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_RO_RD: n_state = ST_RO_WR;
            ST_RO_WR: begin
                if (r_idx[SAW-1:0] == i_stat.total_m1) begin
                    n_outer = '0;
                    n_inner = '0;
                    n_idx   = '0;
                    if (i_stat.code == 8'd0) begin
                        n_state = ST_IDLE;
                    end else if (colour_on) begin
                        n_state = ST_CA_RS;
                    end else begin
                        n_state = ST_H_CTX;
                    end
                end else begin
                    n_state = ST_RO_RD;
                    n_idx   = r_idx + 1'b1;
                    if (i_stat.code[5]) begin
                        if (r_chan == chan_m1) begin
                            n_chan = '0;
                            n_pos  = r_pos + 1'b1;
                        end else begin
                            n_chan = r_chan + 1'b1;
                        end
                    end else begin
                        if (r_pos == i_stat.area_m1) begin
                            n_pos  = '0;
                            n_chan = r_chan + 1'b1;
                        end else begin
                            n_pos = r_pos + 1'b1;
                        end
                    end
                end
            end
            ST_CA_RS: n_state = ST_CA_R0;
            ST_CA_R0: n_state = ST_CA_W0;
            ST_CA_W0: n_state = ST_CA_R1;
            ST_CA_R1: n_state = ST_CA_W1;
            ST_CA_W1: begin
                if (r_idx[POSW-1:0] == i_stat.area_m1) begin
                    n_state = ST_H_CTX;
                    n_outer = '0;
                    n_inner = '0;
                end else begin
                    n_state = ST_CA_RS;
                    n_idx   = r_idx + 1'b1;
                end
            end
            ST_H_CTX: n_state = ST_H_RD;
            ST_H_RD:  n_state = ST_H_WR;
            ST_H_WR: begin
                if (r_inner == edge_m1) begin
                    n_state = ST_H_CWR;
                end else begin
                    n_state = ST_H_RD;
                    n_inner = r_inner + 1'b1;
                end
            end
            ST_H_CWR: begin
                n_inner = '0;
                if (r_outer == i_stat.stride_m1) begin
                    n_state = ST_V_CTX;
                    n_outer = '0;
                end else begin
                    n_state = ST_H_CTX;
                    n_outer = r_outer + 1'b1;
                end
            end
            ST_V_CTX: n_state = ST_V_RD;
            ST_V_RD:  n_state = ST_V_WR;
            ST_V_WR: begin
                if (r_inner == edge_m1) begin
                    n_state = ST_V_CWR;
                end else begin
                    n_state = ST_V_RD;
                    n_inner = r_inner + 1'b1;
                end
            end
            ST_V_CWR: begin
                n_inner = '0;
                if (r_outer == i_stat.stride_m1) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_V_CTX;
                    n_outer = r_outer + 1'b1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_busy     = (r_state != ST_IDLE);
    assign o_dp.op    = r_state;
    assign o_dp.idx   = r_idx;
    assign o_dp.chan  = r_chan;
    assign o_dp.pos   = r_pos;
    assign o_dp.outer = r_outer;
    assign o_dp.inner = r_inner;

endmodule

[hw/rtl/lbr_dp.sv]
// Datapath: sample and context memories, config, counters, adders, result register.
module lbr_dp import lbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_in_item   i_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  t_dp_cmd    i_dp,
    output t_dp_stat   o_stat,
    output logic       o_strobe,
    output t_out_item  o_item
);

    logic [7:0] r_arr_mem  [SAMPLES_MAX];
    logic [7:0] r_blk_mem  [SAMPLES_MAX];
    logic [7:0] r_up_mem   [UP_DEPTH];
    logic [7:0] r_left_mem [LEFT_DEPTH];

    logic [7:0] r_arr_rd, r_blk_rd, r_up_rd, r_left_rd;
    logic [7:0] r_acc, r_s;

    logic [DEGW-1:0] r_deg;
    logic [CHW-1:0]  r_chans;
    logic [CNTW-1:0] r_load_cnt, r_read_cnt;
    logic [7:0]      r_code;
    logic [5:0]      r_col, r_row;
    logic            r_ready;
    logic            r_strobe, r_nr, r_last;

    logic [CHW-1:0]  chans;
    logic [INW:0]    edge_n;
    logic [POSW:0]   area;
    logic [CNTW-1:0] total;
    logic [OW:0]     stride;
    logic [2:0]      sh2;
    logic            load_last;
    logic            do_load, do_read;

    logic [1:0]      src, t0, t1;
    logic [SAW-1:0]  a_src, a_t0, a_t1, a_dest, a_h, a_v;
    logic [POSW-1:0] yy, xx;
    logic [OW-1:0]   vk, vj;
    logic [CAW-1:0]  lbase, ubase, a_left, a_up;

    logic [SAW-1:0]  blk_addr;
    logic            blk_re, blk_we;
    logic [7:0]      blk_wd, nv;

    assign chans  = (r_chans == 3'd0) ? 3'd1 :
                    (r_chans > CHW'(MAX_CHANNELS)) ? CHW'(MAX_CHANNELS) : r_chans;
    assign edge_n = (INW+1)'(1) << r_deg;
    assign sh2    = {r_deg, 1'b0};
    assign area   = (POSW+1)'(1) << sh2;
    assign total  = CNTW'(area) * CNTW'(chans);
    assign stride = (OW+1)'(CNTW'(edge_n) * CNTW'(chans));

    assign load_last = (r_load_cnt + 1'b1) >= total;
    assign do_load   = i_accept && (i_item.cmd == CMD_LOAD);
    assign do_read   = i_accept && (i_item.cmd == CMD_READ);

    assign o_stat.deg       = r_deg;
    assign o_stat.chans     = chans;
    assign o_stat.code      = r_code;
    assign o_stat.total_m1  = SAW'(total - 1'b1);
    assign o_stat.area_m1   = POSW'(area - 1'b1);
    assign o_stat.stride_m1 = OW'(stride - 1'b1);
    assign o_stat.load_last = load_last;
    assign o_cfg_ready      = 1'b1;

    // colour add plane selection
    assign src = r_code[3:2] - 2'd1;
    assign t0  = (src == 2'd0) ? 2'd1 : 2'd0;
    assign t1  = (src == 2'd2) ? 2'd1 : 2'd2;
    assign a_src = (SAW'(src) << sh2) + SAW'(i_dp.idx[POSW-1:0]);
    assign a_t0  = (SAW'(t0) << sh2) + SAW'(i_dp.idx[POSW-1:0]);
    assign a_t1  = (SAW'(t1) << sh2) + SAW'(i_dp.idx[POSW-1:0]);

    assign yy     = i_dp.pos >> r_deg;
    assign xx     = i_dp.pos & POSW'(edge_n - 1'b1);
    assign a_dest = (SAW'(i_dp.chan) << sh2)
                    + (r_code[4] ? (SAW'(yy) + (SAW'(xx) << r_deg)) : SAW'(i_dp.pos));

    assign a_h = (SAW'(i_dp.outer) << r_deg) + SAW'(i_dp.inner);
    assign vk  = i_dp.outer >> r_deg;
    assign vj  = i_dp.outer & OW'(edge_n - 1'b1);
    assign a_v = (SAW'(vk) << sh2) + (SAW'(i_dp.inner) << r_deg) + SAW'(vj);

    assign lbase  = CAW'(r_row) * CAW'(stride);
    assign ubase  = CAW'(r_col) * CAW'(stride);
    assign a_left = lbase + CAW'(i_dp.outer);
    assign a_up   = ubase + CAW'(i_dp.outer);

    assign nv = (i_dp.op == ST_V_WR || r_code[6]) ? (r_acc + r_blk_rd) : r_blk_rd;

    always_comb begin
        blk_addr = a_h;
        blk_re   = 1'b0;
        blk_we   = 1'b0;
        blk_wd   = nv;
        case (i_dp.op)
            ST_IDLE: begin
                blk_addr = r_read_cnt[SAW-1:0];
                blk_re   = do_read && r_ready;
            end
            ST_RO_WR: begin
                blk_addr = a_dest;
                blk_we   = 1'b1;
                blk_wd   = r_arr_rd;
            end
            ST_CA_RS: begin
                blk_addr = a_src;
                blk_re   = 1'b1;
            end
            ST_CA_R0: begin
                blk_addr = a_t0;
                blk_re   = 1'b1;
            end
            ST_CA_W0: begin
                blk_addr = a_t0;
                blk_we   = r_code[0];
                blk_wd   = r_blk_rd + r_s;
            end
            ST_CA_R1: begin
                blk_addr = a_t1;
                blk_re   = 1'b1;
            end
            ST_CA_W1: begin
                blk_addr = a_t1;
                blk_we   = r_code[1];
                blk_wd   = r_blk_rd + r_s;
            end
            ST_H_RD: begin
                blk_addr = a_h;
                blk_re   = 1'b1;
            end
            ST_H_WR: begin
                blk_addr = a_h;
                blk_we   = r_code[6];
            end
            ST_V_RD: begin
                blk_addr = a_v;
                blk_re   = 1'b1;
            end
            ST_V_WR: begin
                blk_addr = a_v;
                blk_we   = 1'b1;
            end
            default: begin
                blk_re = 1'b0;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_arr_mem[r_load_cnt[SAW-1:0]] <= i_item.sample;
        end
        if (i_dp.op == ST_RO_RD) begin
            r_arr_rd <= r_arr_mem[i_dp.idx[SAW-1:0]];
        end
        if (blk_we) begin
            r_blk_mem[blk_addr] <= blk_wd;
        end
        if (blk_re) begin
            r_blk_rd <= r_blk_mem[blk_addr];
        end
        if (i_dp.op == ST_CLEAR) begin
            if (i_dp.idx < CAW'(UP_DEPTH - 1) || i_dp.idx == CAW'(UP_DEPTH - 1)) begin
                r_up_mem[i_dp.idx] <= 8'd0;
            end
            if (i_dp.idx < CAW'(LEFT_DEPTH - 1) || i_dp.idx == CAW'(LEFT_DEPTH - 1)) begin
                r_left_mem[i_dp.idx] <= 8'd0;
            end
        end
        if (i_dp.op == ST_H_CTX) begin
            r_left_rd <= r_left_mem[a_left];
        end
        if (i_dp.op == ST_H_CWR) begin
            r_left_mem[a_left] <= r_acc;
        end
        if (i_dp.op == ST_V_CTX) begin
            r_up_rd <= r_up_mem[a_up];
        end
        if (i_dp.op == ST_V_CWR) begin
            r_up_mem[a_up] <= r_acc;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (i_dp.op == ST_CA_R0) begin
            r_s <= r_blk_rd;
        end
        if (i_dp.op == ST_H_RD && i_dp.inner == '0) begin
            r_acc <= r_left_rd;
        end else if (i_dp.op == ST_V_RD && i_dp.inner == '0) begin
            r_acc <= r_up_rd;
        end else if (i_dp.op == ST_H_WR || i_dp.op == ST_V_WR) begin
            r_acc <= nv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg      <= 2'd3;
            r_chans    <= 3'd3;
            r_load_cnt <= '0;
            r_read_cnt <= '0;
            r_code     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_ready    <= 1'b0;
            r_strobe   <= 1'b0;
            r_nr       <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_strobe <= do_read;
            if (do_load) begin
                if (r_load_cnt == '0) begin
                    r_code <= i_item.code;
                    r_col  <= i_item.block_col;
                    r_row  <= i_item.block_row;
                end
                if (load_last) begin
                    r_load_cnt <= '0;
                    r_read_cnt <= '0;
                    r_ready    <= 1'b1;
                end else begin
                    r_load_cnt <= r_load_cnt + 1'b1;
                end
            end
            if (do_read) begin
                if (!r_ready) begin
                    r_nr   <= 1'b1;
                    r_last <= 1'b0;
                end else begin
                    r_nr <= 1'b0;
                    if (r_read_cnt == total - 1'b1) begin
                        r_last     <= 1'b1;
                        r_read_cnt <= '0;
                        r_ready    <= 1'b0;
                    end else begin
                        r_last     <= 1'b0;
                        r_read_cnt <= r_read_cnt + 1'b1;
                    end
                end
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_DEGREE || i_cfg_index == CFG_CHANNELS) begin
                    r_load_cnt <= '0;
                    r_read_cnt <= '0;
                    r_ready    <= 1'b0;
                end
                if (i_cfg_index == CFG_DEGREE) begin
                    r_deg <= i_cfg_data[DEGW-1:0];
                end
                if (i_cfg_index == CFG_CHANNELS) begin
                    r_chans <= i_cfg_data[CHW-1:0];
                end
            end
        end
    end

    assign o_strobe         = r_strobe;
    assign o_item.pixel     = r_nr ? 8'd0 : r_blk_rd;
    assign o_item.last      = r_last;
    assign o_item.not_ready = r_nr;

endmodule

[hw/rtl/lossless_block_reconstruct.sv]
// Top level of the lossless block reconstruct unit.
// Commands enter on start/i_item and are taken at an edge where start is high
// and busy is low. A load beat stores one residual byte; the beat that
// completes a block starts the rebuild, during which busy is high: a reorder
// pass over every sample, a colour add pass (when enabled), then horizontal
// and vertical passes over every row and column of each plane; a zero code
// runs the reorder pass only. The rebuild loops run one sample at a time
// through the single-port sample memory, each step a read and then a write.
// A read beat returns one result on o_item in the next cycle, marked by
// o_strobe for one cycle; reads can be issued every cycle while busy is low.
// Results cannot be held off by the receiver.
// The config channel (i_cfg_valid/o_cfg_ready) is always ready; a write to
// the degree or channel count drops any partial load and unread block.
// After reset, and after a clear command, busy stays high while both
// neighbour stores are swept to zero. Reset restores block degree 3 and
// three planes.
module lossless_block_reconstruct import lbr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in_item   i_item,
    output logic       o_strobe,
    output t_out_item  o_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic     accept;
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    assign accept = start && !busy;

    lbr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_item.cmd),
        .i_stat   (dp_stat),
        .o_busy   (busy),
        .o_dp     (dp_cmd)
    );

    lbr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_dp        (dp_cmd),
        .o_stat      (dp_stat),
        .o_strobe    (o_strobe),
        .o_item      (o_item)
    );

endmodule
